// File: hw/rtl/dcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw command validator package
// Shared types and constants for the command checker.
// ----------------------------------------------------------------------------
package dcv_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned BUF_W   = 7;
    localparam int unsigned PHASE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [PHASE_W-1:0] FUZZ_PHASE_MAX = 8'd55;

    typedef enum logic [2:0] {
        OP_COPY_RECT  = 3'd0,
        OP_FILL_RECT  = 3'd1,
        OP_LINE       = 3'd2,
        OP_BACKGROUND = 3'd3,
        OP_COLUMN     = 3'd4,
        OP_SPAN       = 3'd5,
        OP_FUZZ       = 3'd6,
        OP_UNKNOWN    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        RS_OK      = 3'd0,
        RS_MISSING = 3'd1,
        RS_BOUNDS  = 3'd2,
        RS_ORDER   = 3'd3,
        RS_OVERLAP = 3'd4,
        RS_INDEX   = 3'd5,
        RS_UNKNOWN = 3'd6
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SURFACE_WIDTH     = 3'd0,
        CFG_SURFACE_HEIGHT    = 3'd1,
        CFG_BUFFERS_PRESENT   = 3'd2,
        CFG_SRC_IS_DST        = 3'd3,
        CFG_FLAT_COUNT        = 3'd4,
        CFG_COLORMAP_COUNT    = 3'd5,
        CFG_TRANSLATION_COUNT = 3'd6,
        CFG_NONE              = 3'd7
    } t_cfg_idx;

    // buffers_present bit positions
    localparam int unsigned BUF_DST   = 0;
    localparam int unsigned BUF_SRC   = 1;
    localparam int unsigned BUF_TEX   = 2;
    localparam int unsigned BUF_FLAT  = 3;
    localparam int unsigned BUF_TRANS = 4;
    localparam int unsigned BUF_CMAP  = 5;
    localparam int unsigned BUF_TMAP  = 6;

    // map_flags bit positions
    localparam int unsigned MAP_TRANS = 0;
    localparam int unsigned MAP_CMAP  = 1;
    localparam int unsigned MAP_TMAP  = 2;

    typedef struct packed {
        logic [COORD_W-1:0] surface_width;
        logic [COORD_W-1:0] surface_height;
        logic [BUF_W-1:0]   buffers_present;
        logic               source_is_destination;
        logic [COUNT_W-1:0] flat_count;
        logic [COUNT_W-1:0] colormap_count;
        logic [COUNT_W-1:0] translation_count;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic [COORD_W-1:0] x_a;
        logic [COORD_W-1:0] y_a;
        logic [COORD_W-1:0] x_b;
        logic [COORD_W-1:0] y_b;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [2:0]         map_flags;
        logic [COORD_W-1:0] flat_index;
        logic [COORD_W-1:0] colormap_index;
        logic [COORD_W-1:0] translation_index;
        logic [PHASE_W-1:0] fuzz_phase;
    } t_cmd;

endpackage
`default_nettype wire

// File: hw/rtl/dcv_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw command validator configuration registers
// Holds surface size, attached buffer mask, source-is-destination flag and table counts.
// ----------------------------------------------------------------------------
module dcv_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dcv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dcv_pkg::t_cfg                      o_cfg
);
    import dcv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SURFACE_WIDTH:     n_cfg.surface_width = i_cfg_data[COORD_W-1:0];
                CFG_SURFACE_HEIGHT:    n_cfg.surface_height = i_cfg_data[COORD_W-1:0];
                CFG_BUFFERS_PRESENT:   n_cfg.buffers_present = i_cfg_data[BUF_W-1:0];
                CFG_SRC_IS_DST:        n_cfg.source_is_destination = i_cfg_data[0];
                CFG_FLAT_COUNT:        n_cfg.flat_count = i_cfg_data[COUNT_W-1:0];
                CFG_COLORMAP_COUNT:    n_cfg.colormap_count = i_cfg_data[COUNT_W-1:0];
                CFG_TRANSLATION_COUNT: n_cfg.translation_count = i_cfg_data[COUNT_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dcv_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw command validator check logic
// Missing-buffer, bounds, order, overlap and index checks; first failing check wins.
// ----------------------------------------------------------------------------
module dcv_check (
    input  wire dcv_pkg::t_cmd i_cmd,
    input  wire dcv_pkg::t_cfg i_cfg,
    output dcv_pkg::t_reason   o_reason
);
    import dcv_pkg::*;

    logic [COUNT_W-1:0] sw;
    logic [COUNT_W-1:0] sh;
    logic [COUNT_W-1:0] xa;
    logic [COUNT_W-1:0] ya;
    logic [COUNT_W-1:0] xb;
    logic [COUNT_W-1:0] yb;
    logic [COUNT_W-1:0] w;
    logic [COUNT_W-1:0] h;
    logic [COUNT_W-1:0] xa_w;
    logic [COUNT_W-1:0] ya_h;
    logic [COUNT_W-1:0] xb_w;
    logic [COUNT_W-1:0] yb_h;
    logic               dst_out;
    logic               src_out;
    logic               overlap;
    logic               flat_bad;
    logic               cmap_bad;
    logic               trans_bad;
    logic [BUF_W-1:0]   bufs;
    logic [2:0]         flags;
    t_reason            maps_reason;
    t_reason            reason;

    assign sw = {1'b0, i_cfg.surface_width};
    assign sh = {1'b0, i_cfg.surface_height};
    assign xa = {1'b0, i_cmd.x_a};
    assign ya = {1'b0, i_cmd.y_a};
    assign xb = {1'b0, i_cmd.x_b};
    assign yb = {1'b0, i_cmd.y_b};
    assign w  = {1'b0, i_cmd.rect_width};
    assign h  = {1'b0, i_cmd.rect_height};

    // 17-bit sums never wrap
    assign xa_w = xa + w;
    assign ya_h = ya + h;
    assign xb_w = xb + w;
    assign yb_h = yb + h;

    assign dst_out = (xa_w > sw) || (ya_h > sh);
    assign src_out = (xb_w > sw) || (yb_h > sh);
    assign overlap = (xa < xb_w) && (xa_w > xb) && (ya < yb_h) && (ya_h > yb);

    assign flat_bad  = {1'b0, i_cmd.flat_index} >= i_cfg.flat_count;
    assign cmap_bad  = {1'b0, i_cmd.colormap_index} >= i_cfg.colormap_count;
    assign trans_bad = {1'b0, i_cmd.translation_index} >= i_cfg.translation_count;

    assign bufs  = i_cfg.buffers_present;
    assign flags = i_cmd.map_flags;

    always_comb begin
        if (flags[MAP_TRANS] && !bufs[BUF_TRANS]) begin
            maps_reason = RS_MISSING;
        end else if (flags[MAP_CMAP] && !bufs[BUF_CMAP]) begin
            maps_reason = RS_MISSING;
        end else if (flags[MAP_TMAP] && !bufs[BUF_TMAP]) begin
            maps_reason = RS_MISSING;
        end else if (flags[MAP_TRANS] && trans_bad) begin
            maps_reason = RS_INDEX;
        end else if (flags[MAP_CMAP] && cmap_bad) begin
            maps_reason = RS_INDEX;
        end else begin
            maps_reason = RS_OK;
        end
    end

    always_comb begin
        reason = RS_OK;
        case (i_cmd.operation)
            OP_COPY_RECT: begin
                if (!bufs[BUF_SRC]) reason = RS_MISSING;
                else if (dst_out || src_out) reason = RS_BOUNDS;
                else if (i_cfg.source_is_destination && overlap) reason = RS_OVERLAP;
            end
            OP_FILL_RECT: begin
                if (dst_out) reason = RS_BOUNDS;
            end
            OP_LINE: begin
                if (xa >= sw || ya >= sh || xb >= sw || yb >= sh) reason = RS_BOUNDS;
            end
            OP_BACKGROUND: begin
                if (!bufs[BUF_FLAT]) reason = RS_MISSING;
                else if (dst_out) reason = RS_BOUNDS;
                else if (flat_bad) reason = RS_INDEX;
            end
            OP_COLUMN: begin
                if (!bufs[BUF_TEX]) reason = RS_MISSING;
                else if (xa >= sw || yb >= sh) reason = RS_BOUNDS;
                else if (yb < ya) reason = RS_ORDER;
                else reason = maps_reason;
            end
            OP_SPAN: begin
                if (!bufs[BUF_FLAT]) reason = RS_MISSING;
                else if (ya >= sh || xb >= sw) reason = RS_BOUNDS;
                else if (xb < xa) reason = RS_ORDER;
                else if (flat_bad) reason = RS_INDEX;
                else reason = maps_reason;
            end
            OP_FUZZ: begin
                // start row, column y range and end row must be ordered
                if (!bufs[BUF_CMAP]) reason = RS_MISSING;
                else if (xa >= sw || h >= sh) reason = RS_BOUNDS;
                else if (w > ya || ya > yb || yb > h) reason = RS_ORDER;
                else if (cmap_bad) reason = RS_INDEX;
                else if (i_cmd.fuzz_phase > FUZZ_PHASE_MAX) reason = RS_INDEX;
            end
            default: begin
                reason = RS_UNKNOWN;
            end
        endcase
    end

    assign o_reason = bufs[BUF_DST] ? reason : RS_MISSING;

endmodule
`default_nettype wire

// File: hw/rtl/draw_command_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Draw command validator
// Path: an accepted item passes through the command register, then the result
// register. Throughput: one item per cycle while the output is not stalled,
// set by the combinational check logic between the two registers.
// Reset: synchronous active low; clears valid flags and all config to 0.
// ----------------------------------------------------------------------------
module draw_command_validator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dcv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dcv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [2:0]                     i_operation,
    input  wire logic [15:0]                    i_x_a,
    input  wire logic [15:0]                    i_y_a,
    input  wire logic [15:0]                    i_x_b,
    input  wire logic [15:0]                    i_y_b,
    input  wire logic [15:0]                    i_rect_width,
    input  wire logic [15:0]                    i_rect_height,
    input  wire logic [2:0]                     i_map_flags,
    input  wire logic [15:0]                    i_flat_index,
    input  wire logic [15:0]                    i_colormap_index,
    input  wire logic [15:0]                    i_translation_index,
    input  wire logic [7:0]                     i_fuzz_phase,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_accepted,
    output logic [2:0]                          o_reject_reason
);
    import dcv_pkg::*;

    t_cfg    cfg;
    t_cmd    r_cmd;
    logic    r_cmd_valid;
    logic    r_out_valid;
    t_reason r_reason;
    t_reason chk_reason;
    logic    out_free;
    logic    cmd_free;
    logic    in_take;

    dcv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dcv_check u_check (
        .i_cmd    (r_cmd),
        .i_cfg    (cfg),
        .o_reason (chk_reason)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign cmd_free   = !r_cmd_valid || out_free;
    assign o_in_stall = !cmd_free;
    assign in_take    = i_in_valid && cmd_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd_free) begin
                r_cmd_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd.operation         <= t_op'(i_operation);
            r_cmd.x_a               <= i_x_a;
            r_cmd.y_a               <= i_y_a;
            r_cmd.x_b               <= i_x_b;
            r_cmd.y_b               <= i_y_b;
            r_cmd.rect_width        <= i_rect_width;
            r_cmd.rect_height       <= i_rect_height;
            r_cmd.map_flags         <= i_map_flags;
            r_cmd.flat_index        <= i_flat_index;
            r_cmd.colormap_index    <= i_colormap_index;
            r_cmd.translation_index <= i_translation_index;
            r_cmd.fuzz_phase        <= i_fuzz_phase;
        end
        if (out_free && r_cmd_valid) begin
            r_reason <= chk_reason;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = (r_reason == RS_OK);
    assign o_reject_reason = r_reason;

endmodule
`default_nettype wire
